// ----- src/aps_pkg.sv -----
// ----------------------------------------------------------------------------
// Amicable pair search package
// Sizes, sequencer states and the result record shared by the search block.
// ----------------------------------------------------------------------------
package aps_pkg;

	// Largest searchable bound; the divisor-sum table holds one entry per number.
	localparam int MAX_LIMIT = 65536;
	localparam int ADDR_W    = $clog2(MAX_LIMIT);
	// Width that holds any clamped limit, the limit itself included.
	localparam int NUM_W     = $clog2(MAX_LIMIT + 1);
	// Multiple counter: one step past the limit must still fit.
	localparam int CNT_W     = NUM_W + 1;
	// Proper-divisor sums stay below four times the number in this range.
	localparam int SUM_W     = NUM_W + 3;

	// Fixed field widths of the two channels.
	localparam int LIMIT_W   = 17;
	localparam int MEMBER_W  = 16;
	localparam int COUNT_W   = 6;
	localparam int WIDE_W    = (LIMIT_W > NUM_W) ? LIMIT_W : NUM_W;

	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(63);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SIEVE,
		ST_SCAN_RD,
		ST_SCAN_S,
		ST_SCAN_CHK,
		ST_EMIT_PAIR,
		ST_EMIT_SUM
	} state_t;

	// One result record handed from the sequencer to the output register.
	typedef struct packed {
		logic                load;
		logic                is_pair;
		logic [MEMBER_W-1:0] larger;
		logic [MEMBER_W-1:0] smaller;
		logic [COUNT_W-1:0]  count;
		logic                last;
	} emit_t;

endpackage

// ----- src/aps_ram.sv -----
// ----------------------------------------------------------------------------
// Generic dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module aps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read, both on the rising edge.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ----- src/aps_seq.sv -----
// ----------------------------------------------------------------------------
// Amicable pair search sequencer
// Clears and sieves the divisor-sum table, scans it and issues result records.
// ----------------------------------------------------------------------------
module aps_seq import aps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start_valid,
	input  logic [LIMIT_W-1:0] limit,
	input  logic               out_free,
	output logic               idle,
	output logic               ram_wr_en,
	output logic [ADDR_W-1:0]  ram_wr_addr,
	output logic [SUM_W-1:0]   ram_wr_data,
	output logic [ADDR_W-1:0]  ram_rd_addr,
	input  logic [SUM_W-1:0]   ram_rd_data,
	output emit_t              emit
);

	state_t             state_q, state_d;
	logic [NUM_W-1:0]   lim_q;
	logic [NUM_W-1:0]   n_q;
	logic [CNT_W-1:0]   m_q;
	logic [ADDR_W-1:0]  s_q;
	logic [COUNT_W-1:0] pair_q;
	logic               pend_s1;
	logic [ADDR_W-1:0]  wr_addr_s1;
	logic [NUM_W-1:0]   wr_add_s1;

	logic [WIDE_W-1:0]  lim_wide;
	logic [NUM_W-1:0]   lim_sat;
	logic [NUM_W-1:0]   n_inc;
	logic               n_more;
	logic               m_in;
	logic [CNT_W-1:0]   chain_next;
	logic               chain_ok;
	logic [CNT_W-1:0]   m_step;
	logic               s_lt_n;
	logic               match;
	logic               room;
	logic [SUM_W-1:0]   acc_sum;

	// Limit clamp and the loop conditions of every phase.
	always_comb begin
		lim_wide   = WIDE_W'(limit);
		lim_sat    = (lim_wide > WIDE_W'(MAX_LIMIT)) ? NUM_W'(MAX_LIMIT)
		                                             : lim_wide[NUM_W-1:0];
		n_inc      = n_q + 1'b1;
		n_more     = n_inc < lim_q;
		m_in       = m_q < CNT_W'(lim_q);
		chain_next = {n_inc, 1'b0};
		chain_ok   = chain_next < CNT_W'(lim_q);
		m_step     = m_q + CNT_W'(n_q);
		s_lt_n     = ram_rd_data < SUM_W'(n_q);
		match      = ram_rd_data == SUM_W'(n_q);
		room       = pair_q != COUNT_MAX;
		// The one accumulating adder of the read-modify-write loop.
		acc_sum    = ram_rd_data + SUM_W'(wr_add_s1);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start_valid) begin
					state_d = (lim_sat != '0) ? ST_CLEAR : ST_EMIT_SUM;
				end
			end
			ST_CLEAR: begin
				if (!n_more) begin
					state_d = ST_SIEVE;
				end
			end
			ST_SIEVE: begin
				if (!m_in && !chain_ok) begin
					state_d = (lim_q > NUM_W'(1)) ? ST_SCAN_RD : ST_EMIT_SUM;
				end
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_S;
			end
			ST_SCAN_S: begin
				if (s_lt_n) begin
					state_d = ST_SCAN_CHK;
				end else if (!n_more) begin
					state_d = ST_EMIT_SUM;
				end
			end
			ST_SCAN_CHK: begin
				if (match && room) begin
					state_d = ST_EMIT_PAIR;
				end else begin
					state_d = n_more ? ST_SCAN_RD : ST_EMIT_SUM;
				end
			end
			ST_EMIT_PAIR: begin
				if (out_free) begin
					state_d = n_more ? ST_SCAN_RD : ST_EMIT_SUM;
				end
			end
			ST_EMIT_SUM: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs: table ports and the result record.
	always_comb begin
		idle        = state_q == ST_IDLE;
		ram_wr_en   = 1'b0;
		ram_wr_addr = wr_addr_s1;
		ram_wr_data = acc_sum;
		ram_rd_addr = n_q[ADDR_W-1:0];
		emit        = '0;
		case (state_q)
			ST_CLEAR: begin
				// The first sieve pass is folded in: every number from two up starts at one.
				ram_wr_en   = 1'b1;
				ram_wr_addr = n_q[ADDR_W-1:0];
				ram_wr_data = (n_q >= NUM_W'(2)) ? SUM_W'(1) : '0;
			end
			ST_SIEVE: begin
				ram_wr_en   = pend_s1;
				ram_rd_addr = m_q[ADDR_W-1:0];
			end
			ST_SCAN_S: begin
				ram_rd_addr = s_lt_n ? ram_rd_data[ADDR_W-1:0] : n_inc[ADDR_W-1:0];
			end
			ST_EMIT_PAIR: begin
				emit.load    = out_free;
				emit.is_pair = 1'b1;
				emit.larger  = MEMBER_W'(n_q);
				emit.smaller = MEMBER_W'(s_q);
				emit.count   = pair_q + 1'b1;
			end
			ST_EMIT_SUM: begin
				emit.load  = out_free;
				emit.count = pair_q;
				emit.last  = 1'b1;
			end
			default: begin
				ram_wr_en = 1'b0;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_s1 <= 1'b0;
			pair_q  <= '0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == ST_SIEVE) && m_in;
			if (state_q == ST_IDLE && start_valid) begin
				pair_q <= '0;
			end else if (state_q == ST_EMIT_PAIR && out_free) begin
				pair_q <= pair_q + 1'b1;
			end
		end
	end

	// Counters and the write stage of the sieve loop.
	always_ff @(posedge clk) begin
		wr_addr_s1 <= m_q[ADDR_W-1:0];
		wr_add_s1  <= n_q;
		case (state_q)
			ST_IDLE: begin
				if (start_valid) begin
					lim_q <= lim_sat;
					n_q   <= '0;
				end
			end
			ST_CLEAR: begin
				if (n_more) begin
					n_q <= n_inc;
				end else begin
					n_q <= NUM_W'(2);
					m_q <= CNT_W'(4);
				end
			end
			ST_SIEVE: begin
				// A chain change leaves one cycle free for the last write to land.
				if (m_in) begin
					m_q <= m_step;
				end else if (chain_ok) begin
					n_q <= n_inc;
					m_q <= chain_next;
				end else begin
					n_q <= NUM_W'(1);
				end
			end
			ST_SCAN_S: begin
				if (s_lt_n) begin
					s_q <= ram_rd_data[ADDR_W-1:0];
				end else begin
					n_q <= n_inc;
				end
			end
			ST_SCAN_CHK: begin
				if (!(match && room)) begin
					n_q <= n_inc;
				end
			end
			ST_EMIT_PAIR: begin
				if (out_free) begin
					n_q <= n_inc;
				end
			end
			default: begin
				s_q <= s_q;
			end
		endcase
	end

endmodule

// ----- src/amicable_pair_sieve_search.sv -----
// ----------------------------------------------------------------------------
// Amicable pair sieve search
// Finds all amicable pairs below a given bound with a divisor-sum sieve.
// ----------------------------------------------------------------------------
// Usage: one transfer on the start channel carries an exclusive bound in
// limit; bounds above the table size are clamped to it. The block then
// stalls the start channel until the whole run is over. The run writes an
// initial pass over the table, sieves with one read-modify-write per cycle
// through the table's single read and write ports, pausing at each change
// of divisor chain, and then scans the table number by number.
// Each amicable pair leaves on the result channel, larger member first,
// with the running count; a summary with last set and the total ends the
// run, and at most 63 pairs are reported. Results wait in an output
// register: while the receiver stalls, the scan holds at the next pair.
// Reset returns the block to idle with no result pending.
// ----------------------------------------------------------------------------
module amicable_pair_sieve_search import aps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start_valid,
	output logic                start_stall,
	input  logic [LIMIT_W-1:0]  limit,
	output logic                result_valid,
	input  logic                result_stall,
	output logic                is_pair,
	output logic [MEMBER_W-1:0] larger_member,
	output logic [MEMBER_W-1:0] smaller_member,
	output logic [COUNT_W-1:0]  pairs_found,
	output logic                last
);

	logic              idle;
	logic              out_free;
	logic              ram_wr_en;
	logic [ADDR_W-1:0] ram_wr_addr;
	logic [SUM_W-1:0]  ram_wr_data;
	logic [ADDR_W-1:0] ram_rd_addr;
	logic [SUM_W-1:0]  ram_rd_data;
	emit_t             emit;
	logic              result_valid_q;

	assign start_stall  = !idle;
	assign out_free     = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;

	aps_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start_valid (start_valid),
		.limit       (limit),
		.out_free    (out_free),
		.idle        (idle),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data),
		.emit        (emit)
	);

	aps_ram #(
		.WIDTH (SUM_W),
		.DEPTH (MAX_LIMIT)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Output register valid: set on a new record, cleared by a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit.load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit.load) begin
			is_pair        <= emit.is_pair;
			larger_member  <= emit.larger;
			smaller_member <= emit.smaller;
			pairs_found    <= emit.count;
			last           <= emit.last;
		end
	end

endmodule

// ----- src/aps_checker.sv -----
// ----------------------------------------------------------------------------
// Amicable pair search checker
// Port-level checks on the start and result channels of the search block.
// ----------------------------------------------------------------------------
module aps_checker import aps_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                start_valid,
	input logic                start_stall,
	input logic [LIMIT_W-1:0]  limit,
	input logic                result_valid,
	input logic                result_stall,
	input logic                is_pair,
	input logic [MEMBER_W-1:0] larger_member,
	input logic [MEMBER_W-1:0] smaller_member,
	input logic [COUNT_W-1:0]  pairs_found,
	input logic                last
);

	// A stalled result holds its valid and payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(is_pair)
			&& $stable(larger_member) && $stable(smaller_member)
			&& $stable(pairs_found) && $stable(last))
		else $error("stalled result changed");

	// A start transfer makes the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		start_valid && !start_stall |=> start_stall)
		else $error("start accepted without the block going busy");

	// The summary carries no members.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> !is_pair && larger_member == '0
			&& smaller_member == '0)
		else $error("summary carries pair data");

	// A pair has its larger member first and a non-zero count.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_pair |-> !last && larger_member > smaller_member
			&& pairs_found != '0)
		else $error("malformed pair result");

endmodule

bind amicable_pair_sieve_search aps_checker u_checker (.*);

// ----- tb/amicable_pair_sieve_search_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Amicable pair sieve search testbench
// Sends search bounds on the start channel and predicts every pair report and
// run summary with its own divisor-sum sieve. Both channels idle and stall
// at random, and each returned transfer is checked field by field in order.
// ----------------------------------------------------------------------------
module amicable_pair_sieve_search_tb;
	import aps_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 3000000;
	localparam int unsigned LONG_HOLD      = 6000;
	localparam int unsigned SETTLE_CYCLES  = 50;
	localparam int unsigned ALL_ONES_BOUND = (1 << LIMIT_W) - 1;

	// One report as it should leave the result channel.
	typedef struct packed {
		logic                is_pair;
		logic [MEMBER_W-1:0] larger;
		logic [MEMBER_W-1:0] smaller;
		logic [COUNT_W-1:0]  count;
		logic                last;
	} pair_report_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start_valid = 1'b0;
	logic                start_stall;
	logic [LIMIT_W-1:0]  limit = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	logic                is_pair;
	logic [MEMBER_W-1:0] larger_member;
	logic [MEMBER_W-1:0] smaller_member;
	logic [COUNT_W-1:0]  pairs_found;
	logic                last;

	// Reports predicted but not yet seen, oldest first.
	pair_report_t pair_reports_due[$];
	pair_report_t head_report;
	int unsigned  div_sum [MAX_LIMIT];

	int unsigned mismatches = 0;
	int unsigned bounds_sent = 0;
	int unsigned max_bound = 0;
	int unsigned pair_reports_seen = 0;
	int unsigned summaries_seen = 0;
	int unsigned idle_cycles = 0;
	int unsigned stall_left = 0;
	bit          calm = 1'b0;
	bit          hold_request = 1'b0;

	amicable_pair_sieve_search i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start_valid    (start_valid),
		.start_stall    (start_stall),
		.limit          (limit),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.is_pair        (is_pair),
		.larger_member  (larger_member),
		.smaller_member (smaller_member),
		.pairs_found    (pairs_found),
		.last           (last)
	);

	always #5 clk = ~clk;

	// Sieve the divisor sums below the clamped bound, then scan for pairs
	// whose smaller member maps back to the larger one.
	function automatic void find_amicable_pairs(input logic [LIMIT_W-1:0] bound_in);
		int unsigned        bound;
		int unsigned        s;
		logic [COUNT_W-1:0] found;
		bound = (bound_in > MAX_LIMIT) ? MAX_LIMIT : int'(bound_in);
		found = '0;
		for (int unsigned n = 0; n < bound; n++)
			div_sum[n] = 0;
		for (int unsigned n = 1; n < bound; n++)
			for (int unsigned m = n + n; m < bound; m += n)
				div_sum[m] += n;
		for (int unsigned n = 1; n < bound; n++) begin
			s = div_sum[n];
			// Perfect numbers and the mirrored half of each pair fail s < n.
			if (s < n && div_sum[s] == n && found < COUNT_MAX) begin
				found++;
				pair_reports_due.push_back('{1'b1, MEMBER_W'(n), MEMBER_W'(s), found, 1'b0});
			end
		end
		pair_reports_due.push_back('{1'b0, '0, '0, found, 1'b1});
	endfunction

	task automatic check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	// Compare each result transfer with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pair_reports_due.size() == 0) begin
				$error("Unexpected result: is_pair %0d larger_member %0d smaller_member %0d",
					is_pair, larger_member, smaller_member);
				mismatches++;
			end else begin
				head_report = pair_reports_due.pop_front();
				check_field("is_pair", head_report.is_pair, is_pair);
				check_field("larger_member", head_report.larger, larger_member);
				check_field("smaller_member", head_report.smaller, smaller_member);
				check_field("pairs_found", head_report.count, pairs_found);
				check_field("last", head_report.last, last);
				if (head_report.last)
					summaries_seen++;
				else
					pair_reports_seen++;
			end
		end
	end

	// Watchdog: a run that stops moving on both channels ends the test.
	always @(posedge clk) begin
		if ((start_valid && !start_stall) || (result_valid && !result_stall)) begin
			idle_cycles = 0;
		end else if (arst_n) begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired after %0d cycles without a transfer.", idle_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 11);
			end
			if (stall_left != 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Offer one bound, with an optional idle burst first, and predict its run.
	task automatic send_limit(input logic [LIMIT_W-1:0] bound);
		int unsigned gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			@(negedge clk);
			start_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start_valid <= 1'b1;
		limit <= bound;
		do @(posedge clk); while (start_stall);
		find_amicable_pairs(bound);
		bounds_sent++;
		if (bound > max_bound)
			max_bound = bound;
	endtask

	// Withdraw the start request and wait for every predicted report.
	task automatic wait_drained();
		@(negedge clk);
		start_valid <= 1'b0;
		while (pair_reports_due.size() != 0)
			@(posedge clk);
	endtask

	// Mostly short searches, with a tail of longer ones that hold more pairs.
	function automatic logic [LIMIT_W-1:0] pick_bound();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return LIMIT_W'($urandom_range(0, 3));
		else if (r < 60)
			return LIMIT_W'($urandom_range(4, 600));
		else if (r < 90)
			return LIMIT_W'($urandom_range(600, 1300));
		else if (r < 98)
			return LIMIT_W'($urandom_range(1300, 3000));
		return LIMIT_W'($urandom_range(3000, 6000));
	endfunction

	// Bounds too small to search anything: summary only, count zero.
	task automatic test_tiny_limits();
		send_limit(0);
		send_limit(1);
		send_limit(2);
		send_limit(3);
	endtask

	// Bounds just past the perfect numbers and around the first pair.
	task automatic test_perfect_numbers();
		send_limit(7);
		send_limit(29);
		send_limit(497);
		send_limit(284);
		send_limit(285);
	endtask

	// A pair appears only once the bound passes its larger member.
	task automatic test_pair_boundaries();
		send_limit(1210);
		send_limit(1211);
		send_limit(2924);
		send_limit(2925);
	endtask

	// Every bit of the bound set: the search clamps to the full table.
	task automatic test_saturated_bound();
		send_limit(LIMIT_W'(ALL_ONES_BOUND));
		wait_drained();
	endtask

	// The receiver holds off for a long stretch while bounds keep coming,
	// so a report waits in the block and the start channel backs up.
	task automatic test_held_results();
		hold_request = 1'b1;
		send_limit(285);
		send_limit(1211);
		send_limit(400);
		send_limit(300);
		wait_drained();
	endtask

	task automatic test_random_bounds(input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_limit(pick_bound());
	endtask

	// Closing stretch with no idling on either side.
	task automatic test_steady_stream();
		calm = 1'b1;
		test_random_bounds(10);
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		test_tiny_limits();
		test_perfect_numbers();
		test_pair_boundaries();
		test_saturated_bound();
		test_held_results();
		test_random_bounds(72);
		test_steady_stream();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Searched %0d bounds up to %0d, including a clamped full-table run.",
			bounds_sent, max_bound);
		$display("Checked %0d pair reports and %0d run summaries, %0d mismatches.",
			pair_reports_seen, summaries_seen, mismatches);
		if (mismatches == 0 && pair_reports_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- amicable_pair_sieve_search.f -----
src/aps_pkg.sv
src/aps_ram.sv
src/aps_seq.sv
src/amicable_pair_sieve_search.sv
src/aps_checker.sv
tb/amicable_pair_sieve_search_tb.sv
